FILE: sv/ipv6hc_pkg.sv
`timescale 1ns / 1ps

package ipv6hc_pkg;

  localparam logic [10:0] BASE_LAST = 11'd39;

  localparam logic [7:0] NH_HOPOPT   = 8'd0;
  localparam logic [7:0] NH_TCP      = 8'd6;
  localparam logic [7:0] NH_UDP      = 8'd17;
  localparam logic [7:0] NH_ROUTING  = 8'd43;
  localparam logic [7:0] NH_FRAG     = 8'd44;
  localparam logic [7:0] NH_GRE      = 8'd47;
  localparam logic [7:0] NH_ESP      = 8'd50;
  localparam logic [7:0] NH_AH       = 8'd51;
  localparam logic [7:0] NH_ICMPV6   = 8'd58;
  localparam logic [7:0] NH_DSTOPT   = 8'd60;
  localparam logic [7:0] NH_MOBILITY = 8'd135;
  localparam logic [7:0] NH_HIP      = 8'd139;
  localparam logic [7:0] NH_SHIM6    = 8'd140;
  localparam logic [7:0] NH_EXP1     = 8'd253;
  localparam logic [7:0] NH_EXP2     = 8'd254;

  localparam int FLAG_HOPOPT  = 0;
  localparam int FLAG_ROUTING = 1;
  localparam int FLAG_FRAG    = 2;
  localparam int FLAG_DSTOPT  = 3;
  localparam int FLAG_AH      = 4;
  localparam int FLAG_ESP     = 5;

  typedef enum logic [2:0] {
    OC_TCP    = 3'd0,
    OC_UDP    = 3'd1,
    OC_GRE    = 3'd2,
    OC_ICMPV6 = 3'd3,
    OC_OTHER  = 3'd4,
    OC_SHORT  = 3'd5
  } outcome_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_packet;
  } byte_item_t;

  typedef struct packed {
    outcome_t    outcome;
    logic [7:0]  final_next_header;
    logic [7:0]  tclass;
    logic [19:0] flow_id;
    logic [7:0]  hops_left;
    logic [15:0] declared_payload_length;
    logic [5:0]  extension_flags;
    logic [7:0]  routing_kind;
    logic [7:0]  segments_remaining;
    logic [12:0] frag_offset;
    logic        frag_more;
    logic [31:0] frag_ident;
  } sum_t;

  function automatic logic is_ext(input logic [7:0] t);
    logic r;
    case (t) inside
      NH_HOPOPT, NH_ROUTING, NH_FRAG, NH_ESP, NH_AH, NH_DSTOPT,
      NH_MOBILITY, NH_HIP, NH_SHIM6, NH_EXP1, NH_EXP2: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/ipv6hc_ifs.sv
`timescale 1ns / 1ps

interface ipv6hc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_packet;

  modport source (output valid, data_byte, end_of_packet, input ready);
  modport sink   (input valid, data_byte, end_of_packet, output ready);
endinterface

interface ipv6hc_sum_if
  import ipv6hc_pkg::*;
();
  logic valid;
  logic ready;
  sum_t payload;

  modport source (output valid, payload, input ready);
  modport sink   (input valid, payload, output ready);
endinterface

FILE: sv/ipv6hc_in_reg.sv
`timescale 1ns / 1ps

module ipv6hc_in_reg
  import ipv6hc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  ipv6hc_byte_if.sink      in_bus,
  output logic             item_valid,
  output byte_item_t       item,
  input  logic             item_take
);

  logic       valid_r;
  byte_item_t item_r;

  assign in_bus.ready = rst_n && (!valid_r || item_take);
  assign item_valid   = valid_r;
  assign item         = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      item_r.data_byte     <= in_bus.data_byte;
      item_r.end_of_packet <= in_bus.end_of_packet;
    end
  end

endmodule

FILE: sv/ipv6hc_core.sv
`timescale 1ns / 1ps

module ipv6hc_core
  import ipv6hc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          item_valid,
  input  byte_item_t    item,
  output logic          item_take,
  ipv6hc_sum_if.source  out_bus
);

  typedef enum logic [1:0] {PH_BASE, PH_WALK, PH_DONE} phase_t;

  phase_t      phase_r, phase_nxt;
  logic [10:0] idx_r, idx_nxt;
  logic [10:0] sect_r, sect_nxt;
  logic [7:0]  cur_r, cur_nxt;
  logic [7:0]  pend_r, pend_nxt;
  logic [27:0] fw_r, fw_nxt;
  logic [15:0] plen_r, plen_nxt;
  logic [7:0]  hop_r, hop_nxt;
  logic [5:0]  flags_r, flags_nxt;
  logic [15:0] rout_r, rout_nxt;
  logic [47:0] frag_r, frag_nxt;
  logic [47:0] scr_r, scr_nxt;
  logic        out_valid_r;
  sum_t        out_r, sum_nxt;

  logic        do_enter;
  logic [7:0]  enter_t;
  logic [7:0]  b;

  assign b         = item.data_byte;
  assign item_take = item_valid && (!item.end_of_packet || !out_valid_r || out_bus.ready);

  assign out_bus.valid   = out_valid_r;
  assign out_bus.payload = out_r;

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    sect_nxt  = sect_r;
    cur_nxt   = cur_r;
    pend_nxt  = pend_r;
    fw_nxt    = fw_r;
    plen_nxt  = plen_r;
    hop_nxt   = hop_r;
    flags_nxt = flags_r;
    rout_nxt  = rout_r;
    frag_nxt  = frag_r;
    scr_nxt   = scr_r;
    do_enter  = 1'b0;
    enter_t   = cur_r;

    case (phase_r)
      PH_BASE: begin
        if (idx_r < 11'd4) begin
          fw_nxt = {fw_r[19:0], b};
        end else if (idx_r < 11'd6) begin
          plen_nxt = {plen_r[7:0], b};
        end else if (idx_r == 11'd6) begin
          cur_nxt = b;
        end else if (idx_r == 11'd7) begin
          hop_nxt = b;
        end
        if (idx_r == BASE_LAST) begin
          do_enter = 1'b1;
          enter_t  = cur_r;
        end else begin
          idx_nxt = idx_r + 11'd1;
        end
      end
      PH_WALK: begin
        if (idx_r == 11'd0) begin
          pend_nxt = b;
        end else if (idx_r == 11'd1) begin
          if (cur_r == NH_AH) begin
            sect_nxt = {1'b0, b, 2'b00} + 11'd7;
          end else begin
            sect_nxt = {b, 3'b111};
          end
        end else if (idx_r < 11'd8) begin
          scr_nxt = {scr_r[39:0], b};
        end
        if (idx_r >= 11'd7 && idx_r == sect_r) begin
          case (cur_r)
            NH_HOPOPT: flags_nxt[FLAG_HOPOPT] = 1'b1;
            NH_ROUTING: begin
              flags_nxt[FLAG_ROUTING] = 1'b1;
              rout_nxt = scr_nxt[47:32];
            end
            NH_FRAG: begin
              flags_nxt[FLAG_FRAG] = 1'b1;
              frag_nxt = scr_nxt;
            end
            NH_DSTOPT: flags_nxt[FLAG_DSTOPT] = 1'b1;
            NH_AH:     flags_nxt[FLAG_AH] = 1'b1;
            default: ;
          endcase
          cur_nxt  = pend_r;
          do_enter = 1'b1;
          enter_t  = pend_r;
        end else begin
          idx_nxt = idx_r + 11'd1;
        end
      end
      default: ;
    endcase

    if (do_enter) begin
      idx_nxt  = '0;
      sect_nxt = '0;
      scr_nxt  = '0;
      pend_nxt = '0;
      if (enter_t == NH_ESP) begin
        flags_nxt[FLAG_ESP] = 1'b1;
        phase_nxt = PH_DONE;
      end else if (is_ext(enter_t)) begin
        phase_nxt = PH_WALK;
      end else begin
        phase_nxt = PH_DONE;
      end
    end
  end

  always_comb begin
    sum_nxt = '0;
    if (phase_nxt == PH_BASE) begin
      sum_nxt.outcome = OC_SHORT;
    end else begin
      case (cur_nxt)
        NH_TCP:    sum_nxt.outcome = OC_TCP;
        NH_UDP:    sum_nxt.outcome = OC_UDP;
        NH_GRE:    sum_nxt.outcome = OC_GRE;
        NH_ICMPV6: sum_nxt.outcome = OC_ICMPV6;
        default:   sum_nxt.outcome = OC_OTHER;
      endcase
      sum_nxt.final_next_header       = cur_nxt;
      sum_nxt.tclass                  = fw_nxt[27:20];
      sum_nxt.flow_id                 = fw_nxt[19:0];
      sum_nxt.hops_left               = hop_nxt;
      sum_nxt.declared_payload_length = plen_nxt;
      sum_nxt.extension_flags         = flags_nxt;
      sum_nxt.routing_kind            = rout_nxt[15:8];
      sum_nxt.segments_remaining      = rout_nxt[7:0];
      sum_nxt.frag_offset             = frag_nxt[47:35];
      sum_nxt.frag_more               = frag_nxt[32];
      sum_nxt.frag_ident              = frag_nxt[31:0];
    end
  end

  // parser state; cleared after every end-of-packet byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_BASE;
      idx_r   <= '0;
      sect_r  <= '0;
      cur_r   <= '0;
      pend_r  <= '0;
      flags_r <= '0;
      rout_r  <= '0;
      frag_r  <= '0;
      scr_r   <= '0;
    end else if (item_take) begin
      if (item.end_of_packet) begin
        phase_r <= PH_BASE;
        idx_r   <= '0;
        sect_r  <= '0;
        cur_r   <= '0;
        pend_r  <= '0;
        flags_r <= '0;
        rout_r  <= '0;
        frag_r  <= '0;
        scr_r   <= '0;
      end else begin
        phase_r <= phase_nxt;
        idx_r   <= idx_nxt;
        sect_r  <= sect_nxt;
        cur_r   <= cur_nxt;
        pend_r  <= pend_nxt;
        flags_r <= flags_nxt;
        rout_r  <= rout_nxt;
        frag_r  <= frag_nxt;
        scr_r   <= scr_nxt;
      end
    end
  end

  // base header fields are fully rewritten by every packet of at least eight bytes
  always_ff @(posedge clk) begin
    if (item_take) begin
      fw_r   <= fw_nxt;
      plen_r <= plen_nxt;
      hop_r  <= hop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (item_take && item.end_of_packet) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take && item.end_of_packet) begin
      out_r <= sum_nxt;
    end
  end

  a_eop_gives_summary: assert property (@(posedge clk) disable iff (!rst_n)
    item_take && item.end_of_packet |=> out_valid_r)
    else $error("summary not raised after end-of-packet transfer");

  a_eop_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    item_take && item.end_of_packet |=> phase_r == PH_BASE && idx_r == 11'd0)
    else $error("parser did not restart after end of packet");

  a_base_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_BASE |-> idx_r <= BASE_LAST)
    else $error("base header index overrun");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_WALK && idx_r > 11'd1 |-> idx_r <= sect_r && sect_r >= 11'd7)
    else $error("extension header index past its end");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_bus.ready |-> !(item_take && item.end_of_packet))
    else $error("pending summary overwritten");

endmodule

FILE: sv/ipv6_header_chain_parser.sv
`timescale 1ns / 1ps

// IPv6 header chain parser.
// in_bus carries one packet byte per transfer, starting at the first byte of
// the fixed 40-byte header; end_of_packet marks the last byte of a packet.
// out_bus carries one summary per packet, raised after its last byte: the
// base header fields, extension presence flags, routing and fragment fields,
// the next header where the walk stopped and a transport class.
// Throughput: one byte per cycle, back to back, while the summary register can
// take each last byte; the parser state updates once per byte, between the
// input register and the summary register.
// With no stall, the last byte sits in the input register while the parser
// computes the summary; out_bus.valid rises once the summary register loads it.
// Reset (synchronous, rst_n low) empties both registers, holds in_bus.ready
// low and returns the parser to the start of the base header; it also
// restarts by itself after every last byte.
// When the receiver stalls, the summary holds; bytes of the next packet keep
// flowing, and only that packet's last byte waits for the summary register.

module ipv6_header_chain_parser
  import ipv6hc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  ipv6hc_byte_if.sink   in_bus,
  ipv6hc_sum_if.source  out_bus
);

  logic       item_valid;
  byte_item_t item;
  logic       item_take;

  ipv6hc_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  ipv6hc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .out_bus    (out_bus)
  );

endmodule
